>>> design/bmm_pkg.sv
// ----------------------------------------------------------------------------
// bmm_pkg - shared types and constants of the bounded multimap table
// Table geometry, operation codes, cell and chain control structs and the
// width conversions between port fields and stored fields.
// ----------------------------------------------------------------------------
package bmm_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int KEY_WIDTH   = 32;
    localparam int VALUE_WIDTH = 32;

    localparam int FIELD_W = 32;
    localparam int TOTAL_W = 5;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    typedef logic [KEY_WIDTH-1:0]   t_key;
    typedef logic [VALUE_WIDTH-1:0] t_val;
    typedef logic [CNT_W-1:0]       t_cnt;

    typedef struct packed {
        t_key key;
        t_val val;
        logic valid;
    } t_entry;

    typedef struct packed {
        logic load;
        logic remove;
        logic capture;
        logic pop;
    } t_cell_cmd;

    typedef struct packed {
        logic add;
        logic remove;
        logic capture;
        logic pop;
        t_cnt slot;
    } t_chain_cmd;

    typedef struct packed {
        logic pair_found;
        logic pend_any;
        logic more;
        t_val sel_val;
    } t_chain_stat;

    function automatic t_key to_key(input logic [FIELD_W-1:0] f);
        logic [KEY_WIDTH+FIELD_W-1:0] ext;
        ext = {{KEY_WIDTH{1'b0}}, f};
        return ext[KEY_WIDTH-1:0];
    endfunction

    function automatic t_val to_val(input logic [FIELD_W-1:0] f);
        logic [VALUE_WIDTH+FIELD_W-1:0] ext;
        ext = {{VALUE_WIDTH{1'b0}}, f};
        return ext[VALUE_WIDTH-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] val_to_field(input t_val v);
        logic [VALUE_WIDTH+FIELD_W-1:0] ext;
        ext = {{FIELD_W{1'b0}}, v};
        return ext[FIELD_W-1:0];
    endfunction

    function automatic logic [TOTAL_W-1:0] cnt_to_total(input t_cnt c);
        logic [CNT_W+TOTAL_W-1:0] ext;
        ext = {{TOTAL_W{1'b0}}, c};
        return ext[TOTAL_W-1:0];
    endfunction

endpackage

>>> design/bmm_cell.sv
// ----------------------------------------------------------------------------
// bmm_cell - one storage cell of the multimap chain
// Holds one pair and its valid bit, registers key and pair matches against
// the broadcast request, and passes the earlier-match flags to its neighbor.
// ----------------------------------------------------------------------------
module bmm_cell import bmm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_key      i_key,
    input  t_val      i_val,
    input  t_entry    i_next,
    output t_entry    o_entry,
    input  logic      i_seen_pair,
    output logic      o_seen_pair,
    input  logic      i_seen_pend,
    output logic      o_seen_pend,
    output logic      o_more,
    output t_val      o_sel_val
);

    t_key r_key, n_key;
    t_val r_val, n_val;
    logic r_valid, n_valid;
    logic r_key_hit, r_pair_hit, r_pend, n_pend;
    logic key_eq, pair_eq, shift, sel;

    always_comb begin
        key_eq      = r_valid && (r_key == i_key);
        pair_eq     = key_eq && (r_val == i_val);
        o_seen_pair = i_seen_pair | r_pair_hit;
        // on a remove, every cell from the first matching pair on takes its neighbor's pair
        shift       = i_cmd.remove & o_seen_pair;
        sel         = r_pend & ~i_seen_pend;
        o_seen_pend = i_seen_pend | r_pend;
        o_more      = r_pend & i_seen_pend;
        o_sel_val   = sel ? r_val : '0;
        o_entry     = '{key: r_key, val: r_val, valid: r_valid};
    end

    always_comb begin
        priority if (i_cmd.load) begin
            n_key   = i_key;
            n_val   = i_val;
            n_valid = 1'b1;
        end else if (shift) begin
            n_key   = i_next.key;
            n_val   = i_next.val;
            n_valid = i_next.valid;
        end else begin
            n_key   = r_key;
            n_val   = r_val;
            n_valid = r_valid;
        end
        priority if (i_cmd.capture) begin
            n_pend = r_key_hit;
        end else if (i_cmd.pop && sel) begin
            n_pend = 1'b0;
        end else begin
            n_pend = r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_key_hit  <= 1'b0;
            r_pair_hit <= 1'b0;
            r_pend     <= 1'b0;
        end else begin
            r_valid    <= n_valid;
            r_key_hit  <= key_eq;
            r_pair_hit <= pair_eq;
            r_pend     <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_val <= n_val;
    end

endmodule

>>> design/bmm_chain.sv
// ----------------------------------------------------------------------------
// bmm_chain - row of storage cells
// Links the cells oldest first, fans out the request and per-cell load,
// and reduces the match chain into a status for the controller.
// ----------------------------------------------------------------------------
module bmm_chain import bmm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_chain_cmd  i_cmd,
    input  t_key        i_key,
    input  t_val        i_val,
    output t_chain_stat o_stat
);

    t_entry    entry    [TABLE_DEPTH];
    t_entry    next     [TABLE_DEPTH];
    t_cell_cmd cell_cmd [TABLE_DEPTH];
    t_val      sel_val  [TABLE_DEPTH];
    logic [TABLE_DEPTH:0]   seen_pair;
    logic [TABLE_DEPTH:0]   seen_pend;
    logic [TABLE_DEPTH-1:0] more;

    assign seen_pair[0] = 1'b0;
    assign seen_pend[0] = 1'b0;

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        always_comb begin
            cell_cmd[i].load    = i_cmd.add && (i_cmd.slot == CNT_W'(i));
            cell_cmd[i].remove  = i_cmd.remove;
            cell_cmd[i].capture = i_cmd.capture;
            cell_cmd[i].pop     = i_cmd.pop;
        end

        if (i == TABLE_DEPTH - 1) begin : g_tail
            assign next[i] = '0;
        end else begin : g_body
            assign next[i] = entry[i+1];
        end

        bmm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (cell_cmd[i]),
            .i_key       (i_key),
            .i_val       (i_val),
            .i_next      (next[i]),
            .o_entry     (entry[i]),
            .i_seen_pair (seen_pair[i]),
            .o_seen_pair (seen_pair[i+1]),
            .i_seen_pend (seen_pend[i]),
            .o_seen_pend (seen_pend[i+1]),
            .o_more      (more[i]),
            .o_sel_val   (sel_val[i])
        );
    end

    always_comb begin
        t_val acc;
        acc = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            acc = acc | sel_val[i];
        end
        o_stat.pair_found = seen_pair[TABLE_DEPTH];
        o_stat.pend_any   = seen_pend[TABLE_DEPTH];
        o_stat.more       = |more;
        o_stat.sel_val    = acc;
    end

endmodule

>>> design/bounded_multimap_table.sv
// ----------------------------------------------------------------------------
// bounded_multimap_table - bounded multimap of (key, value) pairs
// Stores up to TABLE_DEPTH pairs in insertion order in a row of cells.
// ----------------------------------------------------------------------------
// One request is worked at a time. A request is taken in the idle state,
// the cells register their key and pair matches in the look state, and the
// act state decides: for add and remove it writes the result, for a search
// it captures the key matches and the scan state drains the matching cells
// one per cycle in table order (at least one result). A stalled output holds
// the flow. Ready rises again once the last result of a request is loaded
// into the output register, so the next request can be taken while that
// result waits. Remove closes the gap by moving every later pair down one
// cell in the same cycle.
// ----------------------------------------------------------------------------
module bounded_multimap_table import bmm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // key[31:0], value[63:32]
    input  logic [1:0]  i_s_tuser,   // operation[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // ok[0], found_value[32:1], pair_total[37:33], zero[39:38]
    output logic        o_m_tlast    // last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_ACT  = 2'd2;
    localparam logic [1:0] ST_SCAN = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [1:0]         r_op;
    t_key               r_key;
    t_val               r_val;
    t_cnt               r_count, n_count;
    logic               r_m_valid, n_m_valid;
    logic               r_ok, n_ok;
    logic [FIELD_W-1:0] r_found, n_found;
    logic               r_last, n_last;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic               accept, out_free, load_out;
    t_chain_cmd         cmd;
    t_chain_stat        stat;

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_m_valid || i_m_tready;

    bmm_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_key   (r_key),
        .i_val   (r_val),
        .o_stat  (stat)
    );

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        cmd      = '0;
        cmd.slot = r_count;
        load_out = 1'b0;
        n_ok     = 1'b0;
        n_found  = '0;
        n_last   = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_state = ST_ACT;
            end
            ST_ACT: begin
                if (r_op == OP_SEARCH) begin
                    cmd.capture = 1'b1;
                    n_state     = ST_SCAN;
                end else if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                    if (r_op == OP_ADD) begin
                        if (r_count < CNT_W'(TABLE_DEPTH)) begin
                            cmd.add = 1'b1;
                            n_count = r_count + 1'b1;
                            n_ok    = 1'b1;
                        end
                    end else if (r_op == OP_REMOVE) begin
                        if (stat.pair_found) begin
                            cmd.remove = 1'b1;
                            n_count    = r_count - 1'b1;
                            n_ok       = 1'b1;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (stat.pend_any) begin
                        // emit the oldest pending value and drop its mark
                        cmd.pop = 1'b1;
                        n_ok    = 1'b1;
                        n_found = val_to_field(stat.sel_val);
                        n_last  = !stat.more;
                        if (!stat.more) begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_total = cnt_to_total(n_count);
    end

    always_comb begin
        n_m_valid = r_m_valid;
        if (load_out) begin
            n_m_valid = 1'b1;
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_s_tuser;
            r_key <= to_key(i_s_tdata[31:0]);
            r_val <= to_val(i_s_tdata[63:32]);
        end
        if (load_out) begin
            r_ok    <= n_ok;
            r_found <= n_found;
            r_last  <= n_last;
            r_total <= n_total;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {2'b00, r_total, r_found, r_ok};
    assign o_m_tlast  = r_last;

endmodule

>>> design/bmm_checker.sv
// ----------------------------------------------------------------------------
// bmm_checker - port-level checks of the bounded multimap table
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module bmm_checker import bmm_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [63:0] i_s_tdata,
    input logic [1:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata,
    input logic        o_m_tlast
);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled result changed");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request taken while one is in work");

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[37:33] <= TOTAL_W'(TABLE_DEPTH))
        else $error("pair count beyond table depth");

    a_partial_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tdata[0])
        else $error("non-final result without a found value");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> o_m_tdata[32:1] == 32'd0 && o_m_tlast)
        else $error("failed result carries a value or is not final");

endmodule

bind bounded_multimap_table bmm_checker u_bmm_checker (.*);
